// ===== design/raster_tile_ratio_statistics_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the raster tile ratio statistics block
// Clocked on clk, reset by rst_n (active low) in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef RASTER_TILE_RATIO_STATISTICS_TOP_ASSERT_SVH
`define RASTER_TILE_RATIO_STATISTICS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rts assertion failed");
`define RTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rts assertion failed");
`else
`define RTS_ASSERT(lbl, prop)
`define RTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants of the tile ratio statistics block.
// ----------------------------------------------------------------------------
`default_nettype none
package rts_pkg;

  localparam int SUM_W      = 44;
  localparam int CNT_W      = 13;
  localparam int DIVD_W     = 60;
  localparam int DIVS_W     = 44;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 200;
  localparam int HEIGHT_LIM = 4096;

  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [24:0]      MASK25    = 25'h1FFFFFF;

  localparam logic [1:0] CFG_TILE_SIZE = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;
  localparam logic [1:0] CFG_THRESH    = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] nv;
    logic [CNT_W-1:0] ni;
    logic [SUM_W-1:0] bs;
    logic [SUM_W-1:0] fs;
    logic [SUM_W-1:0] rs;
  } entry_t;

  typedef enum logic [1:0] {
    DIV_PIX  = 2'd0,
    DIV_TILE = 2'd1,
    DIV_MEAN = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     cap;
    logic     div_start;
    div_sel_t div_sel;
    logic     upd;
    logic     tr_latch;
    logic     load_out;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic pix_valid;
    logic tile_last;
    logic qualify;
    logic div_busy;
    logic out_free;
  } sts_t;

  function automatic logic [SUM_W-1:0] add_sat44(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/rts_ram.sv =====
// ----------------------------------------------------------------------------
// rts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/rts_div.sv =====
// ----------------------------------------------------------------------------
// rts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_div #(
  parameter int DW = 60,
  parameter int VW = 44
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic      [DW-1:0] quot
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r, dv_r;
  logic [DW-1:0] q_r;
  logic          busy_r;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, q_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dv_r};
  assign busy   = busy_r;
  assign quot   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(DW);
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract when it fits
      rem_r <= ge ? VW'(rem_sh - {1'b0, dv_r}) : rem_sh[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end
endmodule
`default_nettype wire

// ===== design/rts_datapath.sv =====
// ----------------------------------------------------------------------------
// rts_datapath
// Position counters, tile accumulator memory, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_datapath #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_TILE  = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rts_pkg::cmd_t               cmd,
  output rts_pkg::sts_t                    sts,
  input  wire logic [rts_pkg::IN_W-1:0]    in_word,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_idx,
  input  wire logic [31:0]                 cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [rts_pkg::OUT_W-1:0]   out_word
);
  import rts_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int TW = $clog2(MAX_TILE) + 1;
  localparam int OW = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;

  logic [6:0]  ts_r;
  logic [12:0] w_r, h_r;
  logic [31:0] thr_r;

  logic [CW-1:0] col_r;
  logic [11:0]   row_r, trow_r, trow_lat_r;
  logic [OW-1:0] oc_r, orow_r;
  logic [AW-1:0] idx_r, idx_lat_r;
  logic [24:0]   num_r, flag_r;

  logic signed [31:0] b_r, f_r;
  logic    pv_r, first_r, last_r, fend_r;
  entry_t  ent_r, ent_upd, ram_rdata;
  logic [31:0] tr_r;
  logic [OUT_W-1:0] out_r;
  logic    out_v_r;

  logic [TW-1:0]  ts_eff, tsm1;
  logic [CW:0]    w_eff;
  logic [12:0]    h_eff;
  logic           col_wrap, row_wrap, oc_wrap, orow_wrap;
  logic signed [31:0] in_b, in_f;

  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dd, div_q;
  logic [DIVS_W-1:0] div_ds;
  logic [31:0]       ratio, tr_sat, mean_sat;
  logic              above;
  logic [24:0]       flag_nxt;
  logic [31:0]       idx_ext;

  // clamp the geometry registers
  always_comb begin
    if (ts_r == 7'd0) ts_eff = TW'(1);
    else if (int'(ts_r) > MAX_TILE) ts_eff = TW'(MAX_TILE);
    else ts_eff = TW'(ts_r);
    if (w_r == 13'd0) w_eff = (CW+1)'(1);
    else if (int'(w_r) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(w_r);
    if (h_r == 13'd0) h_eff = 13'd1;
    else if (int'(h_r) > HEIGHT_LIM) h_eff = 13'(HEIGHT_LIM);
    else h_eff = h_r;
  end

  assign tsm1      = ts_eff - TW'(1);
  assign in_b      = in_word[31:0];
  assign in_f      = in_word[63:32];
  assign col_wrap  = ({1'b0, col_r} + (CW+1)'(1)) >= w_eff;
  assign row_wrap  = ({1'b0, row_r} + 13'd1) >= h_eff;
  assign oc_wrap   = TW'(oc_r) == tsm1;
  assign orow_wrap = TW'(orow_r) == tsm1;

  // configuration; a geometry write starts a new frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= 7'd1;
      w_r   <= 13'd1;
      h_r   <= 13'd1;
      thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TILE_SIZE: ts_r  <= cfg_wdata[6:0];
        CFG_WIDTH:     w_r   <= cfg_wdata[12:0];
        CFG_HEIGHT:    h_r   <= cfg_wdata[12:0];
        CFG_THRESH:    thr_r <= cfg_wdata;
        default:       thr_r <= thr_r;
      endcase
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && cfg_idx != CFG_THRESH)) begin
      col_r  <= '0;
      row_r  <= '0;
      oc_r   <= '0;
      orow_r <= '0;
      idx_r  <= '0;
      trow_r <= '0;
    end else if (cmd.accept) begin
      if (col_wrap) begin
        col_r <= '0;
        oc_r  <= '0;
        idx_r <= '0;
        if (row_wrap) begin
          row_r  <= '0;
          orow_r <= '0;
          trow_r <= '0;
        end else begin
          row_r  <= row_r + 12'd1;
          orow_r <= orow_wrap ? '0 : orow_r + OW'(1);
          trow_r <= orow_wrap ? trow_r + 12'd1 : trow_r;
        end
      end else begin
        col_r <= col_r + CW'(1);
        oc_r  <= oc_wrap ? '0 : oc_r + OW'(1);
        idx_r <= oc_wrap ? idx_r + AW'(1) : idx_r;
      end
    end
  end

  // latch the pixel and where it sits
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      b_r        <= in_b;
      f_r        <= in_f;
      pv_r       <= (in_b > 0) && (in_f > 0) && (in_b > in_f);
      first_r    <= (oc_r == '0) && (orow_r == '0);
      last_r     <= oc_wrap && orow_wrap;
      fend_r     <= col_wrap && row_wrap;
      idx_lat_r  <= idx_r;
      trow_lat_r <= trow_r;
    end
  end

  rts_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_WIDTH)) u_store (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (idx_lat_r),
    .wdata (ent_upd),
    .re    (cmd.accept),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign ratio = (div_q[DIVD_W-1:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];

  always_comb begin
    ent_upd = ent_r;
    if (pv_r) begin
      if (ent_r.nv < COUNT_MAX) ent_upd.nv = ent_r.nv + CNT_W'(1);
      ent_upd.bs = add_sat44(ent_r.bs, {12'd0, b_r});
      ent_upd.fs = add_sat44(ent_r.fs, {12'd0, f_r});
      ent_upd.rs = add_sat44(ent_r.rs, {12'd0, ratio});
    end else if (ent_r.ni < COUNT_MAX) begin
      ent_upd.ni = ent_r.ni + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ent_r <= first_r ? '0 : ram_rdata;
    end else if (cmd.upd) begin
      ent_r <= ent_upd;
    end
  end

  // shared divider operands
  always_comb begin
    unique case (cmd.div_sel)
      DIV_PIX: begin
        div_dd = {13'd0, b_r[30:0], 16'd0};
        div_ds = {13'd0, f_r[30:0]};
      end
      DIV_TILE: begin
        div_dd = {ent_r.bs, 16'd0};
        div_ds = ent_r.fs;
      end
      DIV_MEAN: begin
        div_dd = {16'd0, ent_r.bs};
        div_ds = {31'd0, ent_r.nv};
      end
      default: begin
        div_dd = '0;
        div_ds = '1;
      end
    endcase
  end

  assign div_start = cmd.div_start;

  rts_div #(.DW(DIVD_W), .VW(DIVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_ds),
    .busy     (div_busy),
    .quot     (div_q)
  );

  assign tr_sat = ratio;

  always_ff @(posedge clk) begin
    if (cmd.tr_latch) begin
      tr_r <= tr_sat;
    end
  end

  assign mean_sat = (div_q[DIVD_W-1:31] != '0) ? 32'h7FFFFFFF : {1'b0, div_q[30:0]};
  assign above    = $signed(mean_sat) >= $signed(thr_r);
  assign flag_nxt = (above && flag_r < MASK25) ? flag_r + 25'd1 : flag_r;
  assign idx_ext  = 32'(idx_lat_r);

  // frame counters; a frame end restarts them after the result is built
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && cfg_idx != CFG_THRESH) || (cmd.finish && fend_r)) begin
      num_r  <= 25'd1;
      flag_r <= '0;
    end else if (cmd.load_out) begin
      num_r  <= (num_r < MASK25) ? num_r + 25'd1 : num_r;
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {4'd0, flag_nxt, above, ent_r.nv, mean_sat, ent_r.rs, tr_r, num_r,
                idx_ext[11:0], trow_lat_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  assign sts.pix_valid = pv_r;
  assign sts.tile_last = last_r;
  assign sts.qualify   = (32'(ent_upd.nv) + 32'(ent_upd.ni) == 32'(ts_eff) * 32'(ts_eff))
                         && (ent_upd.bs != '0) && (ent_upd.fs != '0)
                         && (ent_upd.bs > ent_upd.fs) && (ent_upd.nv > ent_upd.ni);
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_v_r || out_ready;
endmodule
`default_nettype wire

// ===== design/rts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rts_ctrl
// Sequencer for one pixel: read, divide, update, and tile result.
// ----------------------------------------------------------------------------
`default_nettype none
module rts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rts_pkg::sts_t sts,
  output rts_pkg::cmd_t      cmd
);
  import rts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PSTART = 8'b0000_0010,
    S_PWAIT  = 8'b0000_0100,
    S_UPD    = 8'b0000_1000,
    S_TSTART = 8'b0001_0000,
    S_TWAIT  = 8'b0010_0000,
    S_MWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_PIX;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.cap       = 1'b1;
        cmd.div_start = sts.pix_valid;
        state_nxt     = S_PWAIT;
      end
      S_PWAIT: begin
        if (!sts.div_busy) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.tile_last && sts.qualify) begin
          state_nxt = S_TSTART;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TILE;
        state_nxt     = S_TWAIT;
      end
      S_TWAIT: begin
        cmd.div_sel = DIV_TILE;
        if (!sts.div_busy) begin
          cmd.tr_latch  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_nxt     = S_MWAIT;
        end
      end
      S_MWAIT: begin
        cmd.div_sel = DIV_MEAN;
        if (!sts.div_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.div_sel = DIV_MEAN;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

`include "raster_tile_ratio_statistics_top_assert.svh"
  `RTS_ASSERT(a_div_idle_start, cmd.div_start |-> !sts.div_busy)
  `RTS_ASSERT(a_load_free, cmd.load_out |-> sts.out_free)
  `RTS_ASSERT(a_accept_blocks, cmd.accept |=> !in_ready)
  `RTS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> in_ready)
endmodule
`default_nettype wire

// ===== design/raster_tile_ratio_statistics_top.sv =====
// ----------------------------------------------------------------------------
// raster_tile_ratio_statistics_top
// Per-tile valid counts, sums and ratios over a raster biomass/friction stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid/in_tready   | in_tdata: biomass, friction
//  out_    | master    | out_tvalid/out_tready | out_tdata: tile record
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  One word at a time: an invalid pixel skips the division, a valid one
//  waits on the bit-serial divider (one quotient bit per cycle, 60 bits).
//  A qualifying tile end adds two more divisions, tile ratio and mean biomass.
//  Reset is synchronous, active low; the accumulator memory needs no clearing.
//  A result waits in the output register while the next pixel is taken; a
//  further result holds the sequencer until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
module raster_tile_ratio_statistics_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_TILE  = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [31:0] biomass_sample, [63:32] friction_sample
  input  wire logic [63:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [11:0] tile_row_index, [23:12] tile_column_index, [48:24] tile_number,
  // [80:49] total_ratio, [124:81] ratio_sum, [156:125] mean_biomass,
  // [169:157] valid_pixels, [170] above_mean, [195:171] above_mean_count
  output logic [199:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import rts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration is always taken; the user must send it only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  rts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rts_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata)
  );
endmodule
`default_nettype wire
